[hw/rtl/bre_pkg.sv]
// shared types and constants of the bitmap range engine
package bre_pkg;

    // field widths of the request, result and configuration words
    localparam int FUNC_W  = 4;
    localparam int START_W = 12;
    localparam int LEN_W   = 13;
    localparam int SIZE_W  = 13;

    // internal bit positions reach one past the last byte-rounded bit
    localparam int POS_W  = 14;
    localparam int WORD_W = 64;
    localparam int WSEL_W = 6;
    localparam int WIDX_W = POS_W - WSEL_W;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

    // function codes of a request
    localparam logic [FUNC_W-1:0] FN_TEST_ALL  = 4'd0;
    localparam logic [FUNC_W-1:0] FN_TEST_ANY  = 4'd1;
    localparam logic [FUNC_W-1:0] FN_SET_RANGE = 4'd2;
    localparam logic [FUNC_W-1:0] FN_CLR_RANGE = 4'd3;
    localparam logic [FUNC_W-1:0] FN_FLIP_BIT  = 4'd4;
    localparam logic [FUNC_W-1:0] FN_ANY_USED  = 4'd5;
    localparam logic [FUNC_W-1:0] FN_ALL_USED  = 4'd6;
    localparam logic [FUNC_W-1:0] FN_SET_ALL   = 4'd7;
    localparam logic [FUNC_W-1:0] FN_CLR_ALL   = 4'd8;

    // work kinds handed from the front to the back
    typedef enum logic [2:0] {
        OP_DONE,
        OP_TEST_ALL,
        OP_TEST_ANY,
        OP_SET,
        OP_CLR,
        OP_FLIP
    } t_op;

    // classified command: bit range [lo, hi) or a ready result
    typedef struct packed {
        t_op              op;
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
        logic             answer;
        logic             error;
    } t_cmd;

    // result word
    typedef struct packed {
        logic answer;
        logic error;
    } t_rsp;

    // back-end sequencer states
    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_WALK
    } t_bk_state;

endpackage

[hw/rtl/bre_fifo.sv]
// two-entry queue used between the front, the back and the result port
module bre_fifo import bre_pkg::*; #(
    parameter int W = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         w_do_push;
    logic         w_do_pop;

    assign o_full    = (r_cnt == 2'd2);
    assign o_empty   = (r_cnt == 2'd0);
    assign o_data    = r_mem[r_rp];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_do_push) begin
                r_wp <= ~r_wp;
            end
            if (w_do_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[hw/rtl/bre_front.sv]
// front end: size register, request classification and command queue
module bre_front import bre_pkg::*; #(
    parameter int NBITS = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [SIZE_W-1:0]  i_cfg_data,
    input  logic               i_push,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [START_W-1:0] i_start_pos,
    input  logic [LEN_W-1:0]   i_range_len,
    input  logic               i_hold,
    output logic               o_full,
    output t_cmd               o_cmd,
    output logic               o_cmd_valid,
    input  logic               i_cmd_take
);

    localparam int CMD_W = $bits(t_cmd);

    logic [SIZE_W-1:0] r_size;
    logic [SIZE_W-1:0] w_used;
    logic [POS_W-1:0]  w_used_p;
    logic [POS_W-1:0]  w_end;
    logic [POS_W-1:0]  w_round;
    logic              w_bad;
    t_cmd              w_cmd;
    logic              w_q_full;
    logic              w_q_empty;
    logic [CMD_W-1:0]  w_q_data;

    // size register; the user is to write it only while idle, the block itself does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (i_cfg_valid) begin
            r_size <= i_cfg_data;
        end
    end

    // bits in use, clamped to the store size
    assign w_used   = (32'(r_size) > NBITS) ? SIZE_W'(NBITS) : r_size;
    assign w_used_p = POS_W'(w_used);
    assign w_end    = POS_W'(i_start_pos) + POS_W'(i_range_len);
    assign w_bad    = (w_end > w_used_p);
    assign w_round  = (w_used_p + POS_W'(7)) & ~POS_W'(7);

    // classify the request into a walk or an immediate result
    always_comb begin
        w_cmd        = '0;
        w_cmd.op     = OP_DONE;
        w_cmd.lo     = POS_W'(i_start_pos);
        w_cmd.hi     = w_end;
        case (i_func)
            FN_TEST_ALL, FN_TEST_ANY: begin
                if (w_bad) begin
                    w_cmd.error = 1'b1;
                end else if (i_range_len == '0) begin
                    w_cmd.answer = (i_func == FN_TEST_ALL);
                end else begin
                    w_cmd.op = (i_func == FN_TEST_ALL) ? OP_TEST_ALL : OP_TEST_ANY;
                end
            end
            FN_SET_RANGE, FN_CLR_RANGE: begin
                if (w_bad) begin
                    w_cmd.error = 1'b1;
                end else if (i_range_len != '0) begin
                    w_cmd.op = (i_func == FN_SET_RANGE) ? OP_SET : OP_CLR;
                end
            end
            FN_FLIP_BIT: begin
                w_cmd.hi = POS_W'(i_start_pos) + POS_W'(1);
                if (POS_W'(i_start_pos) >= w_used_p) begin
                    w_cmd.error = 1'b1;
                end else begin
                    w_cmd.op = OP_FLIP;
                end
            end
            FN_ANY_USED, FN_ALL_USED: begin
                w_cmd.lo = '0;
                w_cmd.hi = w_used_p;
                if (w_used == '0) begin
                    w_cmd.answer = (i_func == FN_ALL_USED);
                end else begin
                    w_cmd.op = (i_func == FN_ALL_USED) ? OP_TEST_ALL : OP_TEST_ANY;
                end
            end
            FN_SET_ALL, FN_CLR_ALL: begin
                // whole bytes up to the one holding the last bit in use
                w_cmd.lo = '0;
                w_cmd.hi = w_round;
                if (w_used != '0) begin
                    w_cmd.op = (i_func == FN_SET_ALL) ? OP_SET : OP_CLR;
                end
            end
            default: begin
                w_cmd.op = OP_DONE;
            end
        endcase
    end

    assign o_full = w_q_full || i_hold;

    // command queue toward the back end
    bre_fifo #(
        .W(CMD_W)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && !o_full),
        .i_data  (w_cmd),
        .o_full  (w_q_full),
        .i_pop   (i_cmd_take),
        .o_empty (w_q_empty),
        .o_data  (w_q_data)
    );

    assign o_cmd       = t_cmd'(w_q_data);
    assign o_cmd_valid = !w_q_empty;

endmodule

[hw/rtl/bre_back.sv]
// back end: bitmap memory, clearing pass and word-by-word range walker
module bre_back import bre_pkg::*; #(
    parameter int NBITS = 4096
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  logic i_cmd_valid,
    output logic o_cmd_take,
    input  logic i_rsp_full,
    output logic o_rsp_push,
    output t_rsp o_rsp,
    output logic o_clearing
);

    localparam int NWORDS = (NBITS + WORD_W - 1) / WORD_W;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam logic [WORD_W-1:0] ALL_ONES = '1;

    logic [WORD_W-1:0] r_mem [NWORDS];
    logic [WORD_W-1:0] r_rd_data;

    t_bk_state          r_state, n_state;
    logic [AW-1:0]      r_clr, n_clr;
    t_op                r_op, n_op;
    logic [WIDX_W-1:0]  r_cur, n_cur;
    logic [WIDX_W-1:0]  r_lo_w, n_lo_w;
    logic [WSEL_W-1:0]  r_lo_b, n_lo_b;
    logic [WIDX_W-1:0]  r_last_w, n_last_w;
    logic [WSEL_W-1:0]  r_last_b, n_last_b;
    logic               r_acc, n_acc;

    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [WORD_W-1:0]  w_wdata;
    logic               w_re;
    logic [AW-1:0]      w_raddr;
    logic [POS_W-1:0]   w_last;
    logic [WIDX_W-1:0]  w_next;
    logic [WORD_W-1:0]  w_lo_m;
    logic [WORD_W-1:0]  w_hi_m;
    logic [WORD_W-1:0]  w_mask;

    // bitmap memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    // mask of the range bits inside the current word
    assign w_last = i_cmd.hi - POS_W'(1);
    assign w_next = r_cur + WIDX_W'(1);
    assign w_lo_m = (r_cur == r_lo_w) ? (ALL_ONES << r_lo_b) : ALL_ONES;
    assign w_hi_m = (r_cur == r_last_w)
                  ? (ALL_ONES >> (WSEL_W'(WORD_W - 1) - r_last_b)) : ALL_ONES;
    assign w_mask = w_lo_m & w_hi_m;

    assign o_clearing = (r_state == BK_CLEAR);

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    // walk context
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_cur    <= n_cur;
        r_lo_w   <= n_lo_w;
        r_lo_b   <= n_lo_b;
        r_last_w <= n_last_w;
        r_last_b <= n_last_b;
        r_acc    <= n_acc;
    end

    // next state, memory access and result
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_op       = r_op;
        n_cur      = r_cur;
        n_lo_w     = r_lo_w;
        n_lo_b     = r_lo_b;
        n_last_w   = r_last_w;
        n_last_b   = r_last_b;
        n_acc      = r_acc;
        w_we       = 1'b0;
        w_waddr    = AW'(r_cur);
        w_wdata    = r_rd_data;
        w_re       = 1'b0;
        w_raddr    = AW'(w_next);
        o_cmd_take = 1'b0;
        o_rsp_push = 1'b0;
        o_rsp      = '0;
        case (r_state)
            BK_CLEAR: begin
                // zero every word after reset
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                if (r_clr == AW'(NWORDS - 1)) begin
                    n_state = BK_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            BK_IDLE: begin
                if (i_cmd_valid && !i_rsp_full) begin
                    o_cmd_take = 1'b1;
                    if (i_cmd.op == OP_DONE) begin
                        o_rsp_push   = 1'b1;
                        o_rsp.answer = i_cmd.answer;
                        o_rsp.error  = i_cmd.error;
                    end else begin
                        // start the walk with a read of the first word
                        n_op     = i_cmd.op;
                        n_lo_w   = i_cmd.lo[POS_W-1:WSEL_W];
                        n_lo_b   = i_cmd.lo[WSEL_W-1:0];
                        n_last_w = w_last[POS_W-1:WSEL_W];
                        n_last_b = w_last[WSEL_W-1:0];
                        n_cur    = i_cmd.lo[POS_W-1:WSEL_W];
                        n_acc    = (i_cmd.op == OP_TEST_ALL);
                        w_re     = 1'b1;
                        w_raddr  = AW'(i_cmd.lo[POS_W-1:WSEL_W]);
                        n_state  = BK_WALK;
                    end
                end
            end
            BK_WALK: begin
                case (r_op)
                    OP_TEST_ALL: n_acc = r_acc && ((r_rd_data & w_mask) == w_mask);
                    OP_TEST_ANY: n_acc = r_acc || ((r_rd_data & w_mask) != '0);
                    OP_SET: begin
                        w_we    = 1'b1;
                        w_wdata = r_rd_data | w_mask;
                    end
                    OP_CLR: begin
                        w_we    = 1'b1;
                        w_wdata = r_rd_data & ~w_mask;
                    end
                    OP_FLIP: begin
                        w_we    = 1'b1;
                        w_wdata = r_rd_data ^ w_mask;
                    end
                    default: begin
                        w_we = 1'b0;
                    end
                endcase
                if (r_cur == r_last_w) begin
                    // last word done, report
                    o_rsp_push   = 1'b1;
                    o_rsp.answer = ((r_op == OP_TEST_ALL) || (r_op == OP_TEST_ANY))
                                 ? n_acc : 1'b0;
                    n_state      = BK_IDLE;
                end else begin
                    w_re  = 1'b1;
                    n_cur = w_next;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/bitmap_range_engine_top.sv]
// top level of the bitmap range engine
// A status bitmap of NBITS bits held in a memory of 64-bit words. A request
// is classified on entry and queued (two commands deep); errors, zero-length
// tests and range writes, unknown functions and empty-size operations finish
// in the front and are answered by the back without a memory walk. Every other
// request is dispatched and then walks each 64-bit memory word its range touches
// in the single read-modify-write pass of the memory port. Results wait in a
// two-word queue read with empty/pop. After reset the memory is cleared one word
// a cycle while full stays high; the size register may be written then.
module bitmap_range_engine_top import bre_pkg::*; #(
    parameter int NBITS = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [SIZE_W-1:0]  i_cfg_data,
    input  logic               push,
    output logic               full,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [START_W-1:0] i_start_pos,
    input  logic [LEN_W-1:0]   i_range_len,
    output logic               empty,
    input  logic               pop,
    output logic               o_answer,
    output logic               o_range_error
);

    localparam int RSP_W = $bits(t_rsp);

    t_cmd             w_cmd;
    logic             w_cmd_valid;
    logic             w_cmd_take;
    logic             w_clearing;
    logic             w_rsp_full;
    logic             w_rsp_push;
    t_rsp             w_rsp;
    logic [RSP_W-1:0] w_rsp_q;
    t_rsp             w_rsp_out;

    assign o_cfg_ready = 1'b1;

    // front end: classify and queue requests
    bre_front #(
        .NBITS(NBITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_func      (i_func),
        .i_start_pos (i_start_pos),
        .i_range_len (i_range_len),
        .i_hold      (w_clearing),
        .o_full      (full),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_take  (w_cmd_take)
    );

    // back end: walk the memory
    bre_back #(
        .NBITS(NBITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_take  (w_cmd_take),
        .i_rsp_full  (w_rsp_full),
        .o_rsp_push  (w_rsp_push),
        .o_rsp       (w_rsp),
        .o_clearing  (w_clearing)
    );

    // result queue
    bre_fifo #(
        .W(RSP_W)
    ) u_rsp_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rsp_push),
        .i_data  (w_rsp),
        .o_full  (w_rsp_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (w_rsp_q)
    );

    assign w_rsp_out     = t_rsp'(w_rsp_q);
    assign o_answer      = w_rsp_out.answer;
    assign o_range_error = w_rsp_out.error;

endmodule

[tb/sv/bre_scoreboard.sv]
// scoreboard of the bitmap range engine: predicts and checks every result word
`timescale 1ns / 100ps
module bre_scoreboard import bre_pkg::*; #(
    parameter int NBITS = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [SIZE_W-1:0]  i_cfg_data,
    input  logic               i_push,
    input  logic               i_full,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [START_W-1:0] i_start_pos,
    input  logic [LEN_W-1:0]   i_range_len,
    input  logic               i_empty,
    input  logic               i_pop,
    input  logic               i_answer,
    input  logic               i_range_error,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);

    // the map is kept in whole bytes, so set all / clear all can touch unused bits
    localparam int STORE_BITS = ((NBITS + 7) / 8) * 8;

    bit [STORE_BITS-1:0] bitmap_model;
    logic [SIZE_W-1:0]   size_model;
    t_rsp                result_q [$];
    int                  fail_count;
    int                  checked_count;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    // size register value clamped to the map size
    function automatic int unsigned bits_in_use();
        return (size_model > NBITS) ? NBITS : size_model;
    endfunction

    // all-set or any-set over [first, first+len)
    function automatic logic span_hit(int unsigned first, int unsigned len, logic want_all);
        for (int unsigned i = 0; i < len; i++) begin
            if (want_all && !bitmap_model[first + i])
                return 1'b0;
            if (!want_all && bitmap_model[first + i])
                return 1'b1;
        end
        return want_all;
    endfunction

    // whole-byte fill up to the byte holding the last bit in use
    task automatic fill_map(input bit value);
        int unsigned last;
        last = ((bits_in_use() + 7) >> 3) * 8;
        for (int unsigned i = 0; i < last; i++)
            bitmap_model[i] = value;
    endtask

    // apply one request to the bitmap and work out its result word
    task automatic predict_word(input logic [FUNC_W-1:0] fn, input logic [START_W-1:0] st,
                                input logic [LEN_W-1:0] ln, output t_rsp rsp);
        int unsigned used;
        int unsigned first;
        int unsigned count;
        logic        past_end;
        used     = bits_in_use();
        first    = st;
        count    = ln;
        past_end = (first + count) > used;
        rsp      = '0;
        case (fn)
            FN_TEST_ALL, FN_TEST_ANY: begin
                if (past_end)
                    rsp.error = 1'b1;
                else
                    rsp.answer = span_hit(first, count, fn == FN_TEST_ALL);
            end
            FN_SET_RANGE, FN_CLR_RANGE: begin
                if (past_end)
                    rsp.error = 1'b1;
                else
                    for (int unsigned i = 0; i < count; i++)
                        bitmap_model[first + i] = (fn == FN_SET_RANGE);
            end
            FN_FLIP_BIT: begin
                if (first >= used)
                    rsp.error = 1'b1;
                else
                    bitmap_model[first] = ~bitmap_model[first];
            end
            FN_ANY_USED: rsp.answer = span_hit(0, used, 1'b0);
            FN_ALL_USED: rsp.answer = span_hit(0, used, 1'b1);
            FN_SET_ALL:  fill_map(1'b1);
            FN_CLR_ALL:  fill_map(1'b0);
            default: ;
        endcase
    endtask

    // watch the channels: retire result words first, then queue new predictions
    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (!i_rst_n) begin
            bitmap_model  = '0;
            size_model    = SIZE_RESET;
            result_q.delete();
            fail_count    = 0;
            checked_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                size_model = i_cfg_data;
            if (i_pop && !i_empty) begin
                got.answer = i_answer;
                got.error  = i_range_error;
                if (result_q.size() == 0) begin
                    $error("result word with no request waiting: answer=%0b range_error=%0b",
                           got.answer, got.error);
                    fail_count++;
                end else begin
                    want = result_q.pop_front();
                    checked_count++;
                    if (got.answer !== want.answer) begin
                        $error("answer mismatch: expected %0b, actual %0b",
                               want.answer, got.answer);
                        fail_count++;
                    end
                    if (got.error !== want.error) begin
                        $error("range_error mismatch: expected %0b, actual %0b",
                               want.error, got.error);
                        fail_count++;
                    end
                end
            end
            if (i_push && !i_full) begin
                predict_word(i_func, i_start_pos, i_range_len, want);
                result_q.push_back(want);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= result_q.size();
        o_checked    <= checked_count;
    end

endmodule

[tb/sv/tb.sv]
// testbench top of the bitmap range engine: request stimulus, idling and verdict
`timescale 1ns / 100ps
module tb;
    import bre_pkg::*;

    localparam int     NBITS      = 4096;
    localparam int     NUM_PHASES = 8;
    localparam int     SHORT_LEN  = 64;
    localparam int     END_CYCLES = 80;
    localparam longint TIMEOUT_NS = 6_000_000;

    // codes outside the defined functions
    localparam logic [FUNC_W-1:0] FN_UNUSED_LO = FN_CLR_ALL + FUNC_W'(1);
    localparam logic [FUNC_W-1:0] FN_UNUSED_HI = '1;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_valid   = 1'b0;
    logic               cfg_ready;
    logic [SIZE_W-1:0]  cfg_data    = '0;
    logic               push        = 1'b0;
    logic               full;
    logic [FUNC_W-1:0]  func        = '0;
    logic [START_W-1:0] start_pos   = '0;
    logic [LEN_W-1:0]   range_len   = '0;
    logic               empty;
    logic               pop         = 1'b0;
    logic               answer;
    logic               range_error;

    int fail_count;
    int pending;
    int checked;

    int          idle_pct  = 0;
    int          stall_pct = 0;
    int unsigned size_now  = NBITS;
    int          sent_count;
    int          size_writes;
    int unsigned size_plan [NUM_PHASES] = '{4096, 13, 100, 1, 0, 8191, 2048, 4095};

    always #6 clk = ~clk;

    bitmap_range_engine_top #(.NBITS(NBITS)) u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .push         (push),
        .full         (full),
        .i_func       (func),
        .i_start_pos  (start_pos),
        .i_range_len  (range_len),
        .empty        (empty),
        .pop          (pop),
        .o_answer     (answer),
        .o_range_error(range_error)
    );

    bre_scoreboard #(.NBITS(NBITS)) u_scoreboard (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_push       (push),
        .i_full       (full),
        .i_func       (func),
        .i_start_pos  (start_pos),
        .i_range_len  (range_len),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_answer     (answer),
        .i_range_error(range_error),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // result side: random stalls on pop
    always @(posedge clk) begin
        pop <= ($urandom_range(99) >= stall_pct);
    end

    // offer one request word and hold it until accepted, then maybe go idle
    task automatic send_word(input logic [FUNC_W-1:0] fn, input int unsigned st,
                             input int unsigned ln);
        func      <= fn;
        start_pos <= st[START_W-1:0];
        range_len <= ln[LEN_W-1:0];
        push      <= 1'b1;
        do @(posedge clk); while (full);
        sent_count++;
        if ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // stop offering and wait until every result word has come back
    task automatic wait_drained();
        push <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // size register write over the config channel
    task automatic write_size(input int unsigned value);
        cfg_data  <= value[SIZE_W-1:0];
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        size_now = (value[SIZE_W-1:0] > NBITS) ? NBITS : value[SIZE_W-1:0];
        size_writes++;
    endtask

    // mostly in-range requests with short lengths, some boundary and noise words
    task automatic send_random();
        int unsigned       pick;
        int unsigned       shape;
        int unsigned       st;
        int unsigned       ln;
        int unsigned       room;
        logic [FUNC_W-1:0] fn;
        pick = $urandom_range(99);
        if (pick < 15)
            fn = FN_TEST_ALL;
        else if (pick < 30)
            fn = FN_TEST_ANY;
        else if (pick < 45)
            fn = FN_SET_RANGE;
        else if (pick < 60)
            fn = FN_CLR_RANGE;
        else if (pick < 75)
            fn = FN_FLIP_BIT;
        else if (pick < 81)
            fn = FN_ANY_USED;
        else if (pick < 87)
            fn = FN_ALL_USED;
        else if (pick < 91)
            fn = FN_SET_ALL;
        else if (pick < 95)
            fn = FN_CLR_ALL;
        else
            fn = FUNC_W'($urandom_range(FN_UNUSED_HI, FN_UNUSED_LO));
        shape = $urandom_range(99);
        if (size_now == 0 || shape < 8) begin
            st = $urandom;
            ln = $urandom;
        end else begin
            st   = $urandom_range(size_now - 1, 0);
            room = size_now - st;
            if (shape < 15)
                ln = room + $urandom_range(1, 0);
            else if (room > SHORT_LEN && $urandom_range(3) != 0)
                ln = $urandom_range(SHORT_LEN, 0);
            else
                ln = $urandom_range(room, 0);
        end
        send_word(fn, st, ln);
    endtask

    // main stimulus
    initial begin
        int n;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // size written while the memory is still being cleared
        write_size(NBITS);

        // directed words at full size
        send_word(FN_TEST_ALL, 0, 0);
        send_word(FN_TEST_ANY, 4095, 0);
        send_word(FN_ANY_USED, 0, 0);
        send_word(FN_ALL_USED, 0, 0);
        send_word(FN_SET_RANGE, 0, 4096);
        send_word(FN_ALL_USED, 0, 0);
        send_word(FN_TEST_ALL, 4095, 1);
        send_word(FN_CLR_RANGE, 4095, 1);
        send_word(FN_TEST_ANY, 4095, 1);
        send_word(FN_TEST_ALL, 0, 4096);
        send_word(FN_FLIP_BIT, 4095, 0);
        send_word(FN_FLIP_BIT, 0, 8191);
        send_word(FN_TEST_ANY, 0, 1);
        send_word(FN_TEST_ALL, 4095, 2);
        send_word(FN_SET_RANGE, 1, 8191);
        send_word(FN_CLR_RANGE, 4095, 8191);
        send_word(FN_CLR_ALL, 0, 0);
        send_word(FN_ANY_USED, 0, 0);
        send_word(FN_SET_RANGE, 100, 0);
        send_word(FN_SET_ALL, 0, 0);
        send_word(FN_CLR_RANGE, 100, 0);
        send_word(FN_TEST_ANY, 1000, 3000);
        send_word(FN_UNUSED_HI, 4095, 8191);
        send_word(FN_UNUSED_LO, 0, 0);

        // random phases over size settings and idling patterns
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            write_size(size_plan[p]);
            case (p % 4)
                0: begin
                    idle_pct   = 0;
                    stall_pct <= 0;
                end
                1: begin
                    idle_pct   = 47;
                    stall_pct <= 0;
                end
                2: begin
                    idle_pct   = 0;
                    stall_pct <= 47;
                end
                default: begin
                    idle_pct   = 32;
                    stall_pct <= 32;
                end
            endcase
            if (size_now == 0) begin
                // empty map: whole-map words, a flip and a zero-length test
                send_word(FN_ANY_USED, 0, 0);
                send_word(FN_ALL_USED, 0, 0);
                send_word(FN_SET_ALL, 0, 0);
                send_word(FN_CLR_ALL, 0, 0);
                send_word(FN_FLIP_BIT, 0, 0);
                send_word(FN_TEST_ALL, 0, 0);
                n = 40;
            end else begin
                n = 135;
            end
            for (int i = 0; i < n; i++) begin
                // hold off mid phase until everything is back
                if (i == n / 2)
                    wait_drained();
                send_random();
            end
        end

        wait_drained();
        stall_pct <= 0;
        repeat (END_CYCLES) @(posedge clk);
        $display("%0d requests over %0d size settings, from an empty map to sizes past the map",
                 sent_count, size_writes);
        $display("%0d result words checked under four idling patterns", checked);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/bre_pkg.sv
hw/rtl/bre_fifo.sv
hw/rtl/bre_front.sv
hw/rtl/bre_back.sv
hw/rtl/bitmap_range_engine_top.sv
tb/sv/bre_scoreboard.sv
tb/sv/tb.sv
